[rtl/tlbpt_pkg.sv]
// Shared types and constants for the TLB / page table translator.
// No dependencies; imported by the controller, datapath and top level.
package tlbpt_pkg;

  localparam int unsigned PAGE_COUNT  = 256;
  localparam int unsigned FRAME_BYTES = 256;
  localparam int unsigned PAGE_IDX_W  = $clog2(PAGE_COUNT);

  localparam logic [15:0] PAGE_MASK   = 16'hff00;
  localparam logic [15:0] OFFSET_MASK = 16'h00ff;
  localparam int unsigned PAGE_SHIFT  = 8;

  localparam logic [31:0] CNT_MAX = 32'hffff_ffff;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch address, launch page table read
    logic resolve;  // TLB compare, update state, register the result
  } tlbpt_cmd_t;

endpackage

[rtl/tlbpt_ctrl.sv]
// Controller state machine for the translator.
// Depends on tlbpt_pkg; drives the datapath through tlbpt_cmd_t.
module tlbpt_ctrl
  import tlbpt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  output tlbpt_cmd_t cmd_o
);

  localparam logic StIdle   = 1'b0;
  localparam logic StLookup = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign accept = start && !busy;
  assign busy   = (state_q == StLookup);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start) state_d = StLookup;
      end
      StLookup: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.capture = accept;
  assign cmd_o.resolve = (state_q == StLookup);

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("accepted item did not raise busy");
  a_busy_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy) else $error("lookup lasted more than one cycle");
  a_cmd_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.capture && cmd_o.resolve)) else $error("capture and resolve together");

endmodule

[rtl/tlbpt_datapath.sv]
// Datapath: FIFO TLB, page table (valid flops plus frame memory), counters.
// Depends on tlbpt_pkg; sequenced by tlbpt_ctrl commands.
module tlbpt_datapath
  import tlbpt_pkg::*;
#(
  parameter int unsigned TLB_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tlbpt_cmd_t  cmd_i,
  input  logic [15:0] logical_address_i,
  output logic        valid_o,
  output logic [15:0] physical_address_o,
  output logic [7:0]  frame_number_o,
  output logic        tlb_hit_o,
  output logic        page_fault_o,
  output logic [31:0] hit_total_o,
  output logic [31:0] fault_total_o,
  output logic [31:0] access_total_o
);

  // TLB, entry 0 is the newest
  logic [TLB_ENTRIES-1:0] tlb_valid_q;
  logic [7:0]             tlb_page_q  [TLB_ENTRIES];
  logic [7:0]             tlb_frame_q [TLB_ENTRIES];

  // page table
  logic [PAGE_COUNT-1:0]  pt_valid_q;
  logic [7:0]             pt_mem [PAGE_COUNT];
  logic [7:0]             pt_rd_q;

  logic [15:0]            addr_q;
  logic [7:0]             next_frame_q;
  logic [31:0]            hit_cnt_q, fault_cnt_q, access_cnt_q;

  logic [7:0]             page_in, page_q, offset_q;
  logic [PAGE_IDX_W-1:0]  idx_in, idx_q;
  logic                   hit;
  logic [7:0]             hit_frame;
  logic                   fault;
  logic [7:0]             frame;
  logic [15:0]            phys;

  assign page_in  = 8'((logical_address_i & PAGE_MASK) >> PAGE_SHIFT);
  assign idx_in   = PAGE_IDX_W'(page_in % PAGE_COUNT);
  assign page_q   = 8'((addr_q & PAGE_MASK) >> PAGE_SHIFT);
  assign offset_q = 8'(addr_q & OFFSET_MASK);
  assign idx_q    = PAGE_IDX_W'(page_q % PAGE_COUNT);

  // associative search, lowest matching slot wins
  always_comb begin
    hit       = 1'b0;
    hit_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid_q[i] && (tlb_page_q[i] == page_q)) begin
        hit       = 1'b1;
        hit_frame = tlb_frame_q[i];
      end
    end
  end

  assign fault = !hit && !pt_valid_q[idx_q];

  always_comb begin
    if (hit)        frame = hit_frame;
    else if (fault) frame = next_frame_q;
    else            frame = pt_rd_q;
  end

  assign phys = 16'((32'(frame) * FRAME_BYTES) + 32'(offset_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q  <= logical_address_i;
      pt_rd_q <= pt_mem[idx_in];
    end
    if (cmd_i.resolve && fault) begin
      pt_mem[idx_q] <= next_frame_q;
    end
  end

  // TLB payload: push to the front on a fault
  always_ff @(posedge clk_i) begin
    if (cmd_i.resolve && fault) begin
      for (int i = TLB_ENTRIES - 1; i > 0; i--) begin
        tlb_page_q[i]  <= tlb_page_q[i-1];
        tlb_frame_q[i] <= tlb_frame_q[i-1];
      end
      tlb_page_q[0]  <= page_q;
      tlb_frame_q[0] <= next_frame_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlb_valid_q  <= '0;
      pt_valid_q   <= '0;
      next_frame_q <= '0;
      hit_cnt_q    <= '0;
      fault_cnt_q  <= '0;
      access_cnt_q <= '0;
      valid_o      <= 1'b0;
    end else begin
      valid_o <= cmd_i.resolve;
      if (cmd_i.resolve) begin
        if (access_cnt_q != CNT_MAX) access_cnt_q <= access_cnt_q + 32'd1;
        if (hit && (hit_cnt_q != CNT_MAX)) hit_cnt_q <= hit_cnt_q + 32'd1;
        if (fault) begin
          if (fault_cnt_q != CNT_MAX) fault_cnt_q <= fault_cnt_q + 32'd1;
          pt_valid_q[idx_q] <= 1'b1;
          next_frame_q      <= next_frame_q + 8'd1;
          tlb_valid_q       <= (tlb_valid_q << 1) | TLB_ENTRIES'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resolve) begin
      physical_address_o <= phys;
      frame_number_o     <= frame;
      tlb_hit_o          <= hit;
      page_fault_o       <= fault;
    end
  end

  assign hit_total_o    = hit_cnt_q;
  assign fault_total_o  = fault_cnt_q;
  assign access_total_o = access_cnt_q;

  a_flags_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(tlb_hit_o && page_fault_o)) else $error("hit and fault together");
  a_strobe_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(cmd_i.resolve)) else $error("strobe without lookup");
  a_fault_maps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.resolve && fault) |=> (tlb_valid_q[0] && pt_valid_q[$past(idx_q)]))
    else $error("fault did not record the mapping");

endmodule

[rtl/tlb_page_table_translator_core.sv]
// Flow: the accepting edge latches the address and launches the page table read; the lookup
// state registers the result and valid_o. No new item is taken during the lookup state.
// The lookup state is there for the page table frame memory: read launched at acceptance,
// its registered data used in the lookup state, where any fault also writes back.
// Reset (asynchronous, active low) clears TLB and page table valid bits, the free
// frame pointer and all counters; no clearing pass. The receiver cannot stall:
// valid_o is high for exactly one cycle per item.
module tlb_page_table_translator_core
  import tlbpt_pkg::*;
#(
  parameter int unsigned TLB_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] logical_address_i,
  output logic        valid_o,
  output logic [15:0] physical_address_o,
  output logic [7:0]  frame_number_o,
  output logic        tlb_hit_o,
  output logic        page_fault_o,
  output logic [31:0] hit_total_o,
  output logic [31:0] fault_total_o,
  output logic [31:0] access_total_o
);

  tlbpt_cmd_t cmd;

  // Two-state sequencer: idle (ready for an item) and lookup.
  tlbpt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // TLB search, page table, frame allocation and the result register.
  // The counts presented with each item include that item.
  tlbpt_datapath #(
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .logical_address_i  (logical_address_i),
    .valid_o            (valid_o),
    .physical_address_o (physical_address_o),
    .frame_number_o     (frame_number_o),
    .tlb_hit_o          (tlb_hit_o),
    .page_fault_o       (page_fault_o),
    .hit_total_o        (hit_total_o),
    .fault_total_o      (fault_total_o),
    .access_total_o     (access_total_o)
  );

endmodule

[test/tlbpt_translation_check.sv]
// Translation checker for tlb_page_table_translator_core: keeps its own TLB and page map.
// Watches the command and result ports and flags any mismatch. Depends on tlbpt_pkg.
`timescale 1ns / 1ps

module tlbpt_translation_check
  import tlbpt_pkg::*;
#(
  parameter int unsigned TLB_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [15:0] logical_address_i,
  input  logic        valid_i,
  input  logic [15:0] physical_address_i,
  input  logic [7:0]  frame_number_i,
  input  logic        tlb_hit_i,
  input  logic        page_fault_i,
  input  logic [31:0] hit_total_i,
  input  logic [31:0] fault_total_i,
  input  logic [31:0] access_total_i,
  output int          error_count_o,
  output int          pending_count_o
);

  typedef struct packed {
    logic [15:0] phys;
    logic [7:0]  frame;
    logic        hit;
    logic        fault;
    logic [31:0] hits;
    logic [31:0] faults;
    logic [31:0] accesses;
  } translation_t;

  translation_t pending_xlat[$];

  logic        map_vld   [PAGE_COUNT];
  logic [7:0]  map_frame [PAGE_COUNT];
  logic        tlb_vld   [TLB_DEPTH];
  logic [7:0]  tlb_page  [TLB_DEPTH];
  logic [7:0]  tlb_frame [TLB_DEPTH];
  int unsigned tlb_fill;
  logic [8:0]  free_frame;
  logic [31:0] hit_cnt;
  logic [31:0] fault_cnt;
  logic [31:0] access_cnt;
  int          errors;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

  // Updates the local TLB / page map and returns what the block must report.
  function automatic translation_t translate_address(input logic [15:0] addr);
    translation_t res;
    logic [7:0]   page;
    logic [7:0]   frame;
    logic         hit;
    logic         fault;
    int unsigned  idx;
    int unsigned  last;
    page  = 8'((addr & PAGE_MASK) >> PAGE_SHIFT);
    idx   = int'(page) % PAGE_COUNT;
    hit   = 1'b0;
    fault = 1'b0;
    frame = '0;
    access_cnt = sat_inc(access_cnt);
    for (int i = 0; i < TLB_DEPTH; i++) begin
      if (!hit && tlb_vld[i] && tlb_page[i] == page) begin
        hit   = 1'b1;
        frame = tlb_frame[i];
      end
    end
    if (hit) begin
      hit_cnt = sat_inc(hit_cnt);
    end else if (!map_vld[idx]) begin
      frame          = free_frame[7:0];
      map_vld[idx]   = 1'b1;
      map_frame[idx] = frame;
      free_frame     = free_frame + 9'd1;
      if (free_frame == 9'd256) free_frame = '0;
      fault     = 1'b1;
      fault_cnt = sat_inc(fault_cnt);
      // FIFO push at the front, oldest drops off the end
      last = (tlb_fill >= TLB_DEPTH) ? TLB_DEPTH - 1 : tlb_fill;
      for (int i = int'(last); i > 0; i--) begin
        tlb_vld[i]   = tlb_vld[i-1];
        tlb_page[i]  = tlb_page[i-1];
        tlb_frame[i] = tlb_frame[i-1];
      end
      tlb_vld[0]   = 1'b1;
      tlb_page[0]  = page;
      tlb_frame[0] = frame;
      if (tlb_fill < TLB_DEPTH) tlb_fill++;
    end else begin
      frame = map_frame[idx];
    end
    res.phys     = 16'(32'(frame) * FRAME_BYTES + 32'(addr & OFFSET_MASK));
    res.frame    = frame;
    res.hit      = hit;
    res.fault    = fault;
    res.hits     = hit_cnt;
    res.faults   = fault_cnt;
    res.accesses = access_cnt;
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    translation_t want;
    if (!rst_ni) begin
      for (int i = 0; i < PAGE_COUNT; i++) begin
        map_vld[i]   = 1'b0;
        map_frame[i] = '0;
      end
      for (int i = 0; i < TLB_DEPTH; i++) begin
        tlb_vld[i]   = 1'b0;
        tlb_page[i]  = '0;
        tlb_frame[i] = '0;
      end
      tlb_fill   = 0;
      free_frame = '0;
      hit_cnt    = '0;
      fault_cnt  = '0;
      access_cnt = '0;
      errors     = 0;
      pending_xlat.delete();
    end else begin
      // results first, so a stray strobe never pairs with an item taken this edge
      if (valid_i) begin
        if (pending_xlat.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got physical address 0x%0h",
                   $time, physical_address_i);
        end else begin
          want = pending_xlat.pop_front();
          compare_field("physical_address", 32'(want.phys), 32'(physical_address_i));
          compare_field("frame_number", 32'(want.frame), 32'(frame_number_i));
          compare_field("tlb_hit", 32'(want.hit), 32'(tlb_hit_i));
          compare_field("page_fault", 32'(want.fault), 32'(page_fault_i));
          compare_field("hit_total", want.hits, hit_total_i);
          compare_field("fault_total", want.faults, fault_total_i);
          compare_field("access_total", want.accesses, access_total_i);
        end
      end
      if (start_i && !busy_i) pending_xlat.push_back(translate_address(logical_address_i));
    end
    error_count_o   <= errors;
    pending_count_o <= pending_xlat.size();
  end

endmodule

[test/tb_top.sv]
// Top of the translator testbench: clock, reset, address stimulus and the verdict.
// Depends on tlbpt_pkg, tlb_page_table_translator_core and tlbpt_translation_check.
`timescale 1ns / 1ps

module tb_top;
  import tlbpt_pkg::*;

  localparam int unsigned TLB_DEPTH   = 16;
  localparam int          RAND_ITEMS  = 1750;
  localparam int          SWEEP_FROM  = 800;     // random phase index where the page sweep starts
  localparam int          CYCLE_LIMIT = 500000;  // exceeds the run length even with every gap at its longest
  localparam int          DRAIN       = 8;       // extra wait for stray results after the last one

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic [15:0] logical_address_i = '0;

  logic        busy;
  logic        valid_o;
  logic [15:0] physical_address_o;
  logic [7:0]  frame_number_o;
  logic        tlb_hit_o;
  logic        page_fault_o;
  logic [31:0] hit_total_o;
  logic [31:0] fault_total_o;
  logic [31:0] access_total_o;

  int error_count;
  int pending_count;
  int cycle_count = 0;

  // pages sent recently, newest first; reused to get TLB hits and mapped misses
  logic [7:0] recent_pages[$];
  logic [7:0] sweep_order[PAGE_COUNT];

  always #2 clk_i = ~clk_i;

  tlb_page_table_translator_core #(
    .TLB_ENTRIES(TLB_DEPTH)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .logical_address_i  (logical_address_i),
    .valid_o            (valid_o),
    .physical_address_o (physical_address_o),
    .frame_number_o     (frame_number_o),
    .tlb_hit_o          (tlb_hit_o),
    .page_fault_o       (page_fault_o),
    .hit_total_o        (hit_total_o),
    .fault_total_o      (fault_total_o),
    .access_total_o     (access_total_o)
  );

  tlbpt_translation_check #(
    .TLB_DEPTH(TLB_DEPTH)
  ) u_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .busy_i             (busy),
    .logical_address_i  (logical_address_i),
    .valid_i            (valid_o),
    .physical_address_i (physical_address_o),
    .frame_number_i     (frame_number_o),
    .tlb_hit_i          (tlb_hit_o),
    .page_fault_i       (page_fault_o),
    .hit_total_i        (hit_total_o),
    .fault_total_i      (fault_total_o),
    .access_total_i     (access_total_o),
    .error_count_o      (error_count),
    .pending_count_o    (pending_count)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Mostly short gaps, some medium, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // Random address: about half reuse a recent page (hits, or mapped misses once
  // the page has dropped out of the TLB), the rest are fully random.
  function automatic logic [15:0] pick_address();
    logic [7:0] page;
    if (recent_pages.size() > 0 && $urandom_range(99) < 50) begin
      page = recent_pages[$urandom_range(recent_pages.size() - 1)];
      return {page, 8'($urandom)};
    end
    return 16'($urandom);
  endfunction

  // Entered just after a rising edge. Holds start high until the block takes the
  // item, then idles for the given gap. With gap zero start stays high, so the next
  // item follows back to back without start being lowered and raised in one step.
  task automatic send_item(input logic [15:0] addr, input int gap);
    start             <= 1'b1;
    logical_address_i <= addr;
    do @(posedge clk_i); while (busy);
    recent_pages.push_front(addr[15:8]);
    if (recent_pages.size() > 32) void'(recent_pages.pop_back());
    if (gap > 0) begin
      start             <= 1'b0;
      logical_address_i <= 16'($urandom);  // junk while idle, must be ignored
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    int         j;
    logic [7:0] tmp;
    logic [15:0] directed[$];

    // shuffled order of every page, used once to exhaust the free frames
    for (int i = 0; i < PAGE_COUNT; i++) sweep_order[i] = 8'(i);
    for (int i = PAGE_COUNT - 1; i > 0; i--) begin
      j              = $urandom_range(i);
      tmp            = sweep_order[i];
      sweep_order[i] = sweep_order[j];
      sweep_order[j] = tmp;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: first fault, hit on the same page, extreme pages and offsets,
    // then enough new pages to push the first ones out of the TLB, so that a
    // mapped page misses the TLB and is served from the page table.
    directed = '{16'h0000, 16'h00ff, 16'hffff, 16'hff00, 16'h8001, 16'h7ffe};
    for (int p = 1; p < 16; p++) directed.push_back({8'(p), (p % 2) ? 8'hff : 8'h00});
    directed.push_back(16'h0055);  // mapped, evicted from TLB
    directed.push_back(16'hff80);  // mapped, evicted from TLB
    directed.push_back(16'h0f0f);  // still in TLB
    directed.push_back(16'h0aaa);  // still in TLB
    foreach (directed[k]) send_item(directed[k], pick_gap());

    // Random phase. A stretch of back to back items, and a sweep over every page
    // so the free frame pointer wraps and the TLB keeps turning over at full fill.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n >= SWEEP_FROM && n < SWEEP_FROM + PAGE_COUNT)
        send_item({sweep_order[n - SWEEP_FROM], 8'($urandom)},
                  (n >= 300 && n < 500) ? 0 : pick_gap());
      else
        send_item(pick_address(), (n >= 300 && n < 500) ? 0 : pick_gap());
    end

    if (start) begin
      start <= 1'b0;
      @(posedge clk_i);
    end

    // let the outstanding results come back, then keep watching for stray results
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (error_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
